>>> sv/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and the relay lookup table for the relay
// crosspoint controller.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int unsigned LOOP_BITS  = 56;
  localparam int unsigned RELAY_BITS = 2 * LOOP_BITS;
  localparam int unsigned N_IN       = 9;
  localparam int unsigned N_OUT      = 8;
  localparam int unsigned NUM_W      = 4;
  localparam int unsigned RIDX_W     = 7;
  localparam int unsigned MAP_W      = N_OUT * NUM_W;

  typedef enum logic [1:0] {
    OP_CONNECT    = 2'd0,
    OP_DISCONNECT = 2'd1,
    OP_RESET_ALL  = 2'd2,
    OP_STATUS     = 2'd3
  } opcode_t;

  typedef logic [NUM_W-1:0]      owner_t;
  typedef logic [RELAY_BITS-1:0] relay_img_t;
  typedef logic [RIDX_W-1:0]     relay_idx_t;

  typedef struct packed {
    relay_idx_t iso_in;
    relay_idx_t xpt;
    relay_idx_t iso_out;
  } relay_set_t;

  typedef struct packed {
    opcode_t    opcode;
    owner_t     input_number;
    owner_t     output_number;
  } cmd_t;

  // relays for one input/output pair: input isolation, crosspoint, output isolation
  function automatic relay_set_t relay_lookup(input logic [3:0] in_idx,
                                              input logic [2:0] out_idx);
    relay_set_t  rs;
    logic [55:0] xrow;
    logic [13:0] irow;
    logic [5:0]  sel;
    begin
      xrow = '0;
      irow = '0;
      case (in_idx)
        4'd0: begin
          irow = {7'd12, 7'd107};
          xrow = {7'd16, 7'd18, 7'd17, 7'd16, 7'd108, 7'd109, 7'd110, 7'd111};
        end
        4'd1: begin
          irow = {7'd13, 7'd106};
          xrow = {7'd14, 7'd8, 7'd9, 7'd10, 7'd105, 7'd104, 7'd100, 7'd101};
        end
        4'd2: begin
          irow = {7'd21, 7'd102};
          xrow = {7'd11, 7'd15, 7'd23, 7'd22, 7'd103, 7'd99, 7'd97, 7'd98};
        end
        4'd3: begin
          irow = {7'd20, 7'd96};
          xrow = {7'd25, 7'd26, 7'd27, 7'd24, 7'd92, 7'd93, 7'd95, 7'd94};
        end
        4'd4: begin
          irow = {7'd39, 7'd83};
          xrow = {7'd40, 7'd36, 7'd37, 7'd38, 7'd82, 7'd81, 7'd76, 7'd80};
        end
        4'd5: begin
          irow = {7'd41, 7'd77};
          xrow = {7'd46, 7'd47, 7'd43, 7'd42, 7'd78, 7'd74, 7'd75, 7'd79};
        end
        4'd6: begin
          irow = {7'd45, 7'd73};
          xrow = {7'd50, 7'd49, 7'd48, 7'd44, 7'd72, 7'd70, 7'd69, 7'd68};
        end
        4'd7: begin
          irow = {7'd51, 7'd64};
          xrow = {7'd6, 7'd2, 7'd7, 7'd3, 7'd65, 7'd71, 7'd66, 7'd67};
        end
        4'd8: begin
          irow = {7'd5, 7'd59};
          xrow = {7'd54, 7'd55, 7'd4, 7'd0, 7'd63, 7'd62, 7'd60, 7'd61};
        end
        default: begin
          irow = '0;
          xrow = '0;
        end
      endcase
      sel       = {3'b000, out_idx} * 6'd7;
      rs.xpt    = xrow[sel +: RIDX_W];
      rs.iso_in = out_idx[2] ? irow[13:7] : irow[6:0];
      if (in_idx < 4'd4) begin
        case (out_idx)
          3'd0: rs.iso_out = 7'd88;
          3'd1: rs.iso_out = 7'd89;
          3'd2: rs.iso_out = 7'd90;
          3'd3: rs.iso_out = 7'd91;
          3'd4: rs.iso_out = 7'd31;
          3'd5: rs.iso_out = 7'd28;
          3'd6: rs.iso_out = 7'd29;
          default: rs.iso_out = 7'd30;
        endcase
      end else begin
        case (out_idx)
          3'd0: rs.iso_out = 7'd85;
          3'd1: rs.iso_out = 7'd84;
          3'd2: rs.iso_out = 7'd86;
          3'd3: rs.iso_out = 7'd87;
          3'd4: rs.iso_out = 7'd32;
          3'd5: rs.iso_out = 7'd33;
          3'd6: rs.iso_out = 7'd34;
          default: rs.iso_out = 7'd35;
        endcase
      end
      return rs;
    end
  endfunction

endpackage

>>> sv/rcc_if.sv
// ----------------------------------------------------------------------------
// rcc_in_if / rcc_out_if
// Valid/ready channels for commands and results of the crosspoint controller.
// ----------------------------------------------------------------------------
interface rcc_in_if;
  logic                valid;
  logic                ready;
  rcc_pkg::opcode_t    opcode;
  logic [3:0]          input_number;
  logic [3:0]          output_number;

  modport source (output valid, output opcode, output input_number,
                  output output_number, input ready);
  modport sink   (input valid, input opcode, input input_number,
                  input output_number, output ready);
endinterface

interface rcc_out_if;
  logic        valid;
  logic        ready;
  logic        status_code;
  logic [55:0] relay_loop_low;
  logic [55:0] relay_loop_high;
  logic [31:0] connection_map;

  modport source (output valid, output status_code, output relay_loop_low,
                  output relay_loop_high, output connection_map, input ready);
  modport sink   (input valid, input status_code, input relay_loop_low,
                  input relay_loop_high, input connection_map, output ready);
endinterface

>>> sv/relay_crosspoint_controller.sv
// ----------------------------------------------------------------------------
// relay_crosspoint_controller
// 9-input by 8-output relay crosspoint controller with connection table.
// ----------------------------------------------------------------------------
// Each command transaction is applied to the connection table and the
// 112-relay image in the cycle it is accepted; its result (status, both relay
// loops and the connection map after the command) appears in the result
// register on the next cycle. One command is taken every cycle: a command is
// accepted whenever the result register is empty or its result is being
// taken in the same cycle. Throughput is set by the table and relay update,
// which rcc_core computes combinationally.
module relay_crosspoint_controller (
  input  logic       clk,
  input  logic       rst_n,
  rcc_in_if.sink     in_ch,
  rcc_out_if.source  out_ch
);
  import rcc_pkg::*;

  owner_t     owner_r   [N_OUT];
  owner_t     owner_nxt [N_OUT];
  relay_img_t img_r;
  relay_img_t img_nxt;
  logic       status_nxt;
  logic       out_valid_r;
  logic       status_r;
  relay_img_t res_img_r;
  logic [MAP_W-1:0] res_map_r;
  logic [MAP_W-1:0] map_nxt;
  cmd_t       cmd;
  logic       accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cmd.opcode        = in_ch.opcode;
  assign cmd.input_number  = in_ch.input_number;
  assign cmd.output_number = in_ch.output_number;

  rcc_core u_core (
    .cmd       (cmd),
    .owner_cur (owner_r),
    .img_cur   (img_r),
    .owner_nxt (owner_nxt),
    .img_nxt   (img_nxt),
    .status    (status_nxt)
  );

  always_comb begin
    for (int k = 0; k < N_OUT; k++)
      map_nxt[k*NUM_W +: NUM_W] = owner_nxt[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_OUT; k++)
        owner_r[k] <= '0;
      img_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        owner_r     <= owner_nxt;
        img_r       <= img_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      res_img_r <= img_nxt;
      res_map_r <= map_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status_code     = status_r;
  assign out_ch.relay_loop_low  = res_img_r[LOOP_BITS-1:0];
  assign out_ch.relay_loop_high = res_img_r[RELAY_BITS-1:LOOP_BITS];
  assign out_ch.connection_map  = res_map_r;

endmodule

>>> sv/rcc_core.sv
// ----------------------------------------------------------------------------
// rcc_core
// Next-state logic: applies one command to the connection table and the
// relay image.
// ----------------------------------------------------------------------------
module rcc_core (
  input  rcc_pkg::cmd_t      cmd,
  input  rcc_pkg::owner_t    owner_cur [rcc_pkg::N_OUT],
  input  rcc_pkg::relay_img_t img_cur,
  output rcc_pkg::owner_t    owner_nxt [rcc_pkg::N_OUT],
  output rcc_pkg::relay_img_t img_nxt,
  output logic               status
);
  import rcc_pkg::*;

  logic [2:0] out_idx;
  logic [3:0] in_idx;
  logic [3:0] own_idx;
  logic       in_ok;
  logic       out_ok;
  logic       shared;
  owner_t     cur_owner;
  relay_set_t conn_set;
  relay_set_t disc_set;

  assign out_idx   = 3'(cmd.output_number - 4'd1);
  assign in_idx    = cmd.input_number - 4'd1;
  assign in_ok     = (cmd.input_number != 4'd0) && (cmd.input_number <= 4'(N_IN));
  assign out_ok    = (cmd.output_number != 4'd0) && (cmd.output_number <= 4'(N_OUT));
  assign cur_owner = owner_cur[out_idx];
  assign own_idx   = cur_owner - 4'd1;
  assign conn_set  = relay_lookup(in_idx, out_idx);
  assign disc_set  = relay_lookup(own_idx, out_idx);

  always_comb begin
    shared = 1'b0;
    for (int k = 0; k < N_OUT; k++) begin
      if ((3'(k) != out_idx) && (k[2] == out_idx[2]) && (owner_cur[k] == cur_owner))
        shared = 1'b1;
    end
  end

  always_comb begin
    owner_nxt = owner_cur;
    img_nxt   = img_cur;
    status    = 1'b0;
    case (cmd.opcode)
      OP_CONNECT: begin
        if (in_ok && out_ok && (cur_owner == '0)) begin
          owner_nxt[out_idx]        = cmd.input_number;
          img_nxt[conn_set.iso_in]  = 1'b1;
          img_nxt[conn_set.xpt]     = 1'b1;
          img_nxt[conn_set.iso_out] = 1'b1;
        end else begin
          status = 1'b1;
        end
      end
      OP_DISCONNECT: begin
        if (out_ok && (cur_owner != '0)) begin
          owner_nxt[out_idx]        = '0;
          img_nxt[disc_set.xpt]     = 1'b0;
          img_nxt[disc_set.iso_out] = 1'b0;
          if (!shared)
            img_nxt[disc_set.iso_in] = 1'b0;
        end
      end
      OP_RESET_ALL: begin
        for (int k = 0; k < N_OUT; k++)
          owner_nxt[k] = '0;
        img_nxt = '0;
      end
      default: begin
        status = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/rcc_checker.sv
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks for the relay crosspoint controller, bound to the top.
// ----------------------------------------------------------------------------
module rcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status_code,
  input logic [55:0] out_relay_loop_low,
  input logic [55:0] out_relay_loop_high,
  input logic [31:0] out_connection_map
);
  import rcc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted transaction gave no result");

  a_reset_all: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_RESET_ALL) |=>
      (out_relay_loop_low == '0) && (out_relay_loop_high == '0) &&
      (out_connection_map == '0) && !out_status_code)
    else $error("reset all left state behind");

  a_status_connect: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode != OP_CONNECT) |=> !out_status_code)
    else $error("refusal reported for a non-connect transaction");

endmodule

bind relay_crosspoint_controller rcc_checker u_rcc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_opcode           (in_ch.opcode),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_status_code     (out_ch.status_code),
  .out_relay_loop_low  (out_ch.relay_loop_low),
  .out_relay_loop_high (out_ch.relay_loop_high),
  .out_connection_map  (out_ch.connection_map)
);
